// ===== rtl/cbl_pkg.sv =====
// shared types, constants and index tables of the centered bar renderer
`default_nettype none
package cbl_pkg;

  localparam int unsigned FULL_SCALE_UNIT = 4096;
  localparam int unsigned BAR_HEIGHT      = 8;
  localparam int unsigned HALF_BAR        = BAR_HEIGHT / 2;

  localparam int unsigned LEVEL_W     = 20;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned LIT_W       = 3;   // lit count 0..4
  localparam int unsigned POS_W       = 3;   // dot position in a column
  localparam int unsigned STEP_W      = 4;   // beat number in a burst, 0..9
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COLOR_W-1:0] b;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] r;
  } rgb_t;

  // one classified level: everything the back end needs to emit the burst
  typedef struct packed {
    logic             side;
    logic [LIT_W-1:0] n;
    rgb_t             lit;
    rgb_t             dim_f;
    rgb_t             dim_c;
  } cmd_t;

  // rows: {side, column}
  localparam logic [IDX_W-1:0] COL_TAB [0:3][0:BAR_HEIGHT-1] = '{
    '{8'd241, 8'd206, 8'd177, 8'd142, 8'd113, 8'd78, 8'd49, 8'd14},
    '{8'd240, 8'd207, 8'd176, 8'd143, 8'd112, 8'd79, 8'd48, 8'd15},
    '{8'd238, 8'd209, 8'd174, 8'd145, 8'd110, 8'd81, 8'd46, 8'd17},
    '{8'd239, 8'd208, 8'd175, 8'd144, 8'd111, 8'd80, 8'd47, 8'd16}
  };

  function automatic logic [IDX_W-1:0] led_pos(input logic side, input logic col,
                                                input logic [POS_W-1:0] pos);
    return COL_TAB[{side, col}][pos];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/centered_bar_led_renderer_top.sv =====
// top level of the centered two-column led bar renderer
// usage:
//   in_ channel: one beat per level; in_tdata carries level, red, green and
//   blue, in_tuser picks the left (0) or right (1) meter's index tables
//   out_ channel: one beat per led write (chain index plus color); out_tlast
//   marks the final write of a level's burst
//   a full meter gives 8 writes, otherwise 2*lit + 4 writes (4 to 10)
// path: a level goes through the front register (loaded at the edge that
//   accepts its input beat), then the queue, then the output register
// throughput: the back end emits one write per cycle unless out_tready
//   is low; bursts follow each other with no gap, and the front and a
//   2-deep queue take new levels while a burst is running
// reset: rst_n low at a clock edge empties the front register, the queue
//   and the output register; no other state is kept
// stall: out_tready low holds the current write on out_tdata; the queue
//   fills and then in_tready drops until the back end drains it
`default_nettype none
module centered_bar_led_renderer_top #(
  parameter int unsigned FULL_SCALE_UNIT = cbl_pkg::FULL_SCALE_UNIT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [19:0] level, [27:20] red, [35:28] green, [43:36] blue, [47:44] zero
  input  wire logic [cbl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] side
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] led_index, [15:8] out_red, [23:16] out_green, [31:24] out_blue
  output logic [cbl_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);
  import cbl_pkg::*;

  // input beat unpacking
  logic [LEVEL_W-1:0] in_level;
  rgb_t               in_color;

  assign in_level   = in_tdata[LEVEL_W-1:0];
  assign in_color.r = in_tdata[LEVEL_W +: COLOR_W];
  assign in_color.g = in_tdata[LEVEL_W + COLOR_W +: COLOR_W];
  assign in_color.b = in_tdata[LEVEL_W + 2*COLOR_W +: COLOR_W];

  // front to queue
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;

  // queue to back
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  cbl_front #(
    .FULL_SCALE_UNIT (FULL_SCALE_UNIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_level  (in_level),
    .in_color  (in_color),
    .in_side   (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  cbl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // back end drives the output register directly
  cbl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/cbl_front.sv =====
// front end: accepts a level, works out lit count and dimmed colours
`default_nettype none
module cbl_front #(
  parameter int unsigned FULL_SCALE_UNIT = cbl_pkg::FULL_SCALE_UNIT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cbl_pkg::LEVEL_W-1:0]   in_level,
  input  wire cbl_pkg::rgb_t                 in_color,
  input  wire logic                          in_side,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output cbl_pkg::cmd_t                      cmd
);
  import cbl_pkg::*;

  localparam int unsigned Full = 8 * FULL_SCALE_UNIT;
  localparam int unsigned RemW = (Full > 1) ? $clog2(Full) : 1;
  localparam int unsigned SumW = LEVEL_W + 3;
  localparam int unsigned ProdW = RemW + COLOR_W;

  logic                s1_v_r;
  rgb_t                s1_color_r;
  logic                s1_side_r;
  logic [LIT_W-1:0]    s1_n_r;
  logic [RemW-1:0]     s1_remf_r;
  logic [RemW-1:0]     s1_remc_r;

  logic [LEVEL_W+1:0]  lvl4;
  logic [SumW-1:0]     sum;
  logic [SumW-1:0]     lit;
  logic [LIT_W-1:0]    n;
  logic [RemW-1:0]     remf;
  logic [RemW-1:0]     remc;
  logic                accept;

  function automatic logic [COLOR_W-1:0] dim_chan(input logic [COLOR_W-1:0] c,
                                                  input logic [RemW-1:0] rem);
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] q;
    prod = ProdW'(c) * ProdW'(rem);
    q    = ProdW'(prod / Full);
    return q[COLOR_W-1:0] + COLOR_W'(1);
  endfunction

  function automatic rgb_t dim_color(input rgb_t c, input logic [RemW-1:0] rem);
    rgb_t d;
    d.r = dim_chan(c.r, rem);
    d.g = dim_chan(c.g, rem);
    d.b = dim_chan(c.b, rem);
    // keep a dim dot from going dark
    if (d.b < COLOR_W'(2)) begin
      d.b = COLOR_W'(2);
      if (d.r < COLOR_W'(2)) d.r = COLOR_W'(2);
      if (d.g < COLOR_W'(2)) d.g = COLOR_W'(2);
    end
    return d;
  endfunction

  always_comb begin
    lvl4 = {in_level, 2'b00};
    sum  = SumW'(lvl4) + SumW'(Full / 2);
    lit  = SumW'(sum / Full);
    n    = (lit > SumW'(HALF_BAR)) ? LIT_W'(HALF_BAR) : lit[LIT_W-1:0];
    remc = RemW'(lvl4 % Full);
    remf = RemW'(in_level % Full);
  end

  assign in_ready = !s1_v_r || cmd_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_color_r <= in_color;
      s1_side_r  <= in_side;
      s1_n_r     <= n;
      s1_remf_r  <= remf;
      s1_remc_r  <= remc;
    end
  end

  assign cmd_valid = s1_v_r;

  always_comb begin
    cmd.side  = s1_side_r;
    cmd.n     = s1_n_r;
    cmd.lit   = s1_color_r;
    cmd.dim_f = dim_color(s1_color_r, s1_remf_r);
    cmd.dim_c = dim_color(s1_color_r, s1_remc_r);
  end

endmodule
`default_nettype wire

// ===== rtl/cbl_queue.sv =====
// short command queue between front and back end
`default_nettype none
module cbl_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire cbl_pkg::cmd_t   wr_cmd,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output cbl_pkg::cmd_t        rd_cmd
);
  import cbl_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntW-1:0]  count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CntW'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cbl_back.sv =====
// back end: walks one command into its burst of led writes
`default_nettype none
module cbl_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire cbl_pkg::cmd_t                     cmd,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cbl_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);
  import cbl_pkg::*;

  logic                busy_r;
  cmd_t                cmd_r;
  logic [STEP_W-1:0]   k_r;
  logic                out_v_r;
  logic [IDX_W-1:0]    idx_r;
  rgb_t                color_r;
  logic                last_r;

  cmd_t                cur;
  logic [STEP_W-1:0]   k;
  logic [STEP_W-1:0]   n4;
  logic [STEP_W-1:0]   n2;
  logic [STEP_W-1:0]   last_k;
  logic                have;
  logic                slot_free;
  logic                emit;
  logic                is_last;
  logic [IDX_W-1:0]    idx;
  rgb_t                color;
  logic [STEP_W-1:0]   pos;

  assign cur       = busy_r ? cmd_r : cmd;
  assign k         = busy_r ? k_r : '0;
  assign have      = busy_r || cmd_valid;
  assign slot_free = !out_v_r || out_tready;
  assign emit      = have && slot_free;
  assign cmd_ready = !busy_r && slot_free;

  always_comb begin
    n4      = STEP_W'(cur.n);
    n2      = {cur.n, 1'b0};
    last_k  = (cur.n == LIT_W'(HALF_BAR)) ? STEP_W'(2 * HALF_BAR - 1) : n2 + STEP_W'(3);
    is_last = (k == last_k);
    pos     = '0;
    idx     = '0;
    color   = cur.lit;
    if (k < n4) begin
      // column 1 upward from the center
      pos   = STEP_W'(HALF_BAR) + k;
      idx   = led_pos(cur.side, 1'b1, pos[POS_W-1:0]);
      color = cur.lit;
    end else if (k < n2) begin
      // column 1 downward from the center
      pos   = STEP_W'(HALF_BAR - 1) + n4 - k;
      idx   = led_pos(cur.side, 1'b1, pos[POS_W-1:0]);
      color = cur.lit;
    end else if (k == n2) begin
      idx   = led_pos(cur.side, 1'b0, POS_W'(HALF_BAR - 1));
      color = cur.dim_f;
    end else if (k == n2 + STEP_W'(1)) begin
      idx   = led_pos(cur.side, 1'b0, POS_W'(HALF_BAR));
      color = cur.dim_f;
    end else if (k == n2 + STEP_W'(2)) begin
      pos   = STEP_W'(HALF_BAR) + n4;
      idx   = led_pos(cur.side, 1'b1, pos[POS_W-1:0]);
      color = cur.dim_c;
    end else begin
      pos   = STEP_W'(HALF_BAR - 1) - n4;
      idx   = led_pos(cur.side, 1'b1, pos[POS_W-1:0]);
      color = cur.dim_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (emit) begin
        busy_r  <= !is_last;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_r   <= cur;
      k_r     <= k + STEP_W'(1);
      idx_r   <= idx;
      color_r <= color;
      last_r  <= is_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {color_r.b, color_r.g, color_r.r, idx_r};
  assign out_tlast  = last_r;

endmodule
`default_nettype wire
